// File: design/vna_pkg.sv
// vna_pkg: constants and types shared by the vertex normal averager
// depends on: nothing
`default_nettype none
package vna_pkg;
    localparam int VertexCountDef = 1024;
    localparam int CoordWidthDef  = 16;
    localparam int AccumWidthDef  = 20;
    localparam int IdxW           = 10;
    localparam int FieldW         = 16;
    localparam int UnitOne        = 16384;
    localparam int NormHigh       = 24;
    localparam int NormLow        = 23;
    localparam int MagW           = 64;

    localparam logic [1:0] ACT_LOAD = 2'd0;
    localparam logic [1:0] ACT_TRI  = 2'd1;
    localparam logic [1:0] ACT_READ = 2'd2;

    typedef struct packed {
        logic [1:0]        action;
        logic [IdxW-1:0]   vertex_index;
        logic [FieldW-1:0] pos_x;
        logic [FieldW-1:0] pos_y;
        logic [FieldW-1:0] pos_z;
        logic [IdxW-1:0]   corner_a;
        logic [IdxW-1:0]   corner_b;
        logic [IdxW-1:0]   corner_c;
    } vna_in_t;

    typedef struct packed {
        logic [FieldW-1:0] normal_x;
        logic [FieldW-1:0] normal_y;
        logic [FieldW-1:0] normal_z;
        logic              degenerate;
    } vna_out_t;

    // control between sequencer and scaling unit
    typedef struct packed {
        logic start;
        logic busy;
        logic done;
    } vna_unit_ctl_t;
endpackage
`default_nettype wire

// File: design/vna_if.sv
// vna_if: valid/ready channel carrying one payload type
// depends on: nothing
`default_nettype none
interface vna_if #(parameter type payload_t = logic) ();
    logic     valid;
    logic     ready;
    payload_t payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface
`default_nettype wire

// File: design/vna_ram.sv
// vna_ram: generic single-port synchronous ram, registered read
// depends on: nothing
`default_nettype none
module vna_ram #(
    parameter int Width = 8,
    parameter int Depth = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(Depth)-1:0] addr,
    input  wire logic [Width-1:0]         wdata,
    output logic      [Width-1:0]         rdata
);
    logic [Width-1:0] mem [Depth];

    // write and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule
`default_nettype wire

// File: design/vna_scale.sv
// vna_scale: multi-cycle unit-vector scaling (normalize, isqrt, divide)
// depends on: vna_pkg
`default_nettype none
module vna_scale
    import vna_pkg::*;
#(
    parameter int InW = 40
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  start,
    input  wire logic signed [InW-1:0] in_x,
    input  wire logic signed [InW-1:0] in_y,
    input  wire logic signed [InW-1:0] in_z,
    output logic                       done,
    output logic                       zero,
    output logic signed [FieldW-1:0]   out_x,
    output logic signed [FieldW-1:0]   out_y,
    output logic signed [FieldW-1:0]   out_z
);
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_NORM = 3'd1;
    localparam logic [2:0] S_SQ   = 3'd2;
    localparam logic [2:0] S_SQRT = 3'd3;
    localparam logic [2:0] S_DIV  = 3'd4;
    localparam logic [2:0] S_FIN  = 3'd5;
    localparam int MW = 25;
    localparam int SW = 52;
    localparam int QW = 16;
    localparam int DW = MW + 15;

    logic [2:0]          state_reg;
    logic [InW-1:0]      m_reg [3];
    logic [2:0]          neg_reg;
    logic [1:0]          comp_reg;
    logic [SW-1:0]       sum_reg;
    logic [SW-1:0]       rem_reg;
    logic [SW-1:0]       root_reg;
    logic [SW-1:0]       bit_reg;
    logic [DW-1:0]       num_reg;
    logic [DW-1:0]       drem_reg;
    logic [QW-1:0]       q_reg;
    logic [5:0]          cnt_reg;
    logic [QW-1:0]       res_reg [3];
    logic                zero_reg;
    logic                done_reg;

    logic [InW-1:0] mx;
    logic [MW-1:0]  len;
    logic [DW-1:0]  shl;
    logic [DW:0]    trial;

    // largest magnitude
    always_comb
    begin
        mx = m_reg[0];
        if (m_reg[1] > mx)
        begin
            mx = m_reg[1];
        end
        if (m_reg[2] > mx)
        begin
            mx = m_reg[2];
        end
    end

    assign len   = root_reg[MW-1:0];
    assign shl   = {drem_reg[DW-2:0], num_reg[DW-1]};
    assign trial = {1'b0, shl} - {{(DW+1-MW){1'b0}}, len};

    // sequencer: one shift, one root step or one quotient bit a cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        neg_reg   <= {in_z[InW-1], in_y[InW-1], in_x[InW-1]};
                        m_reg[0]  <= in_x[InW-1] ? -in_x : in_x;
                        m_reg[1]  <= in_y[InW-1] ? -in_y : in_y;
                        m_reg[2]  <= in_z[InW-1] ? -in_z : in_z;
                        state_reg <= S_NORM;
                    end
                end
                S_NORM:
                begin
                    if (mx == '0)
                    begin
                        zero_reg  <= 1'b1;
                        res_reg[0] <= '0;
                        res_reg[1] <= '0;
                        res_reg[2] <= '0;
                        done_reg  <= 1'b1;
                        state_reg <= S_IDLE;
                    end
                    else if (mx >= (InW'(1) << NormHigh))
                    begin
                        for (int i = 0; i < 3; i++)
                        begin
                            m_reg[i] <= m_reg[i] >> 1;
                        end
                    end
                    else if (mx < (InW'(1) << NormLow))
                    begin
                        for (int i = 0; i < 3; i++)
                        begin
                            m_reg[i] <= m_reg[i] << 1;
                        end
                    end
                    else
                    begin
                        zero_reg  <= 1'b0;
                        comp_reg  <= 2'd0;
                        sum_reg   <= '0;
                        state_reg <= S_SQ;
                    end
                end
                S_SQ:
                begin
                    sum_reg <= sum_reg + SW'(m_reg[comp_reg][MW-1:0] * m_reg[comp_reg][MW-1:0]);
                    if (comp_reg == 2'd2)
                    begin
                        root_reg  <= '0;
                        bit_reg   <= SW'(1) << (SW - 2);
                        state_reg <= S_SQRT;
                    end
                    else
                    begin
                        comp_reg <= comp_reg + 2'd1;
                    end
                end
                S_SQRT:
                begin
                    if (bit_reg == '0)
                    begin
                        comp_reg  <= 2'd0;
                        num_reg   <= DW'(m_reg[0][MW-1:0]) * DW'(UnitOne)
                                     + DW'(root_reg[MW-1:1]);
                        drem_reg  <= '0;
                        cnt_reg   <= '0;
                        state_reg <= S_DIV;
                    end
                    else
                    begin
                        if (rem_reg >= root_reg + bit_reg)
                        begin
                            rem_reg  <= rem_reg - root_reg - bit_reg;
                            root_reg <= (root_reg >> 1) + bit_reg;
                        end
                        else
                        begin
                            root_reg <= root_reg >> 1;
                        end
                        bit_reg <= bit_reg >> 2;
                    end
                end
                S_DIV:
                begin
                    // restoring division, one quotient bit per cycle
                    num_reg <= num_reg << 1;
                    if (!trial[DW])
                    begin
                        drem_reg <= trial[DW-1:0];
                        q_reg    <= {q_reg[QW-2:0], 1'b1};
                    end
                    else
                    begin
                        drem_reg <= shl;
                        q_reg    <= {q_reg[QW-2:0], 1'b0};
                    end
                    if (cnt_reg == 6'(DW - 1))
                    begin
                        state_reg <= S_FIN;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg + 6'd1;
                    end
                end
                S_FIN:
                begin
                    res_reg[comp_reg] <= neg_reg[comp_reg] ? -q_reg : q_reg;
                    if (comp_reg == 2'd2)
                    begin
                        done_reg  <= 1'b1;
                        state_reg <= S_IDLE;
                    end
                    else
                    begin
                        comp_reg  <= comp_reg + 2'd1;
                        num_reg   <= DW'(m_reg[comp_reg+2'd1][MW-1:0]) * DW'(UnitOne)
                                     + DW'(root_reg[MW-1:1]);
                        drem_reg  <= '0;
                        cnt_reg   <= '0;
                        state_reg <= S_DIV;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
            if (state_reg == S_SQ && comp_reg == 2'd2)
            begin
                rem_reg <= sum_reg + SW'(m_reg[2][MW-1:0] * m_reg[2][MW-1:0]);
            end
        end
    end

    assign done  = done_reg;
    assign zero  = zero_reg;
    assign out_x = res_reg[0];
    assign out_y = res_reg[1];
    assign out_z = res_reg[2];
endmodule
`default_nettype wire

// File: design/vertex_normal_averager.sv
// vertex_normal_averager top level: command sequencer, position and accumulator rams
// depends on: vna_pkg, vna_if, vna_ram, vna_scale
//
// usage: items arrive on in_ch (valid/ready); action 0 loads a vertex position and
// clears its accumulator, action 1 adds a triangle's unit normal into the three
// corner accumulators, action 2 reads back the normalized accumulated normal on
// out_ch. only reads produce a transfer on out_ch. codes other than 0..2 are dropped.
// one item is worked at a time: a load finishes on its transfer, a triangle passes
// through 3 position reads, edges, the cross product, the scaling unit (normalize
// shifts, root steps and a bit-serial division per component) and 3
// read-modify-writes; a read passes through an accumulator read and a scaling run
// (a zero vector finishes sooner). the iterative scaling unit and the single port
// of each ram set how long an item takes.
// the result sits in an output register; while the receiver stalls the block holds
// it and keeps taking loads and triangles, but a following read waits before its
// scaling run until the pending result has been transferred.
// reset clears the sequencer only; ram contents are undefined until a vertex is
// loaded, and a vertex must be loaded before it is used.
`default_nettype none
module vertex_normal_averager
    import vna_pkg::*;
#(
    parameter int VertexCount = VertexCountDef,
    parameter int CoordWidth  = CoordWidthDef,
    parameter int AccumWidth  = AccumWidthDef
) (
    input  wire logic clk,
    input  wire logic rst_n,
    vna_if.sink       in_ch,
    vna_if.source     out_ch
);
    localparam int AW  = $clog2(VertexCount);
    localparam int PW  = 3 * CoordWidth;
    localparam int NW  = 3 * AccumWidth;
    localparam int EW  = CoordWidth + 1;
    localparam int CW  = 2 * EW + 1;
    localparam int SIW = (CW > AccumWidth) ? CW : AccumWidth;

    localparam logic [3:0] T_IDLE  = 4'd0;
    localparam logic [3:0] T_RDA   = 4'd1;
    localparam logic [3:0] T_RDB   = 4'd2;
    localparam logic [3:0] T_RDC   = 4'd3;
    localparam logic [3:0] T_EDGE  = 4'd4;
    localparam logic [3:0] T_MUL   = 4'd5;
    localparam logic [3:0] T_SCALE = 4'd6;
    localparam logic [3:0] T_ACRD  = 4'd7;
    localparam logic [3:0] T_ACWR  = 4'd8;
    localparam logic [3:0] T_RNRD  = 4'd9;
    localparam logic [3:0] T_RNW   = 4'd10;
    localparam logic [3:0] T_OUT   = 4'd11;
    localparam logic [3:0] T_RNGO  = 4'd12;

    logic [3:0]             state_reg;
    vna_in_t                item_reg;
    logic [1:0]             corner_reg;
    logic signed [CoordWidth-1:0] pa_reg [3];
    logic signed [CoordWidth-1:0] pb_reg [3];
    logic signed [EW-1:0]   e1_reg [3];
    logic signed [EW-1:0]   e2_reg [3];
    logic signed [CW-1:0]   cr_reg [3];
    logic signed [FieldW-1:0] n_reg [3];
    vna_out_t               out_reg;
    logic                   out_valid_reg;
    logic [1:0]             mul_reg;

    logic          pos_we;
    logic [AW-1:0] pos_addr;
    logic [PW-1:0] pos_wdata;
    logic [PW-1:0] pos_rdata;
    logic          acc_we;
    logic [AW-1:0] acc_addr;
    logic [NW-1:0] acc_wdata;
    logic [NW-1:0] acc_rdata;

    logic                     sc_start;
    logic                     sc_done;
    logic signed [SIW-1:0]    sc_in [3];
    logic                     sc_zero;
    logic signed [FieldW-1:0] sc_out [3];

    vna_ram #(.Width(PW), .Depth(VertexCount)) u_pos_ram (
        .clk(clk), .we(pos_we), .addr(pos_addr), .wdata(pos_wdata), .rdata(pos_rdata)
    );
    vna_ram #(.Width(NW), .Depth(VertexCount)) u_acc_ram (
        .clk(clk), .we(acc_we), .addr(acc_addr), .wdata(acc_wdata), .rdata(acc_rdata)
    );

    vna_scale #(.InW(SIW)) u_scale (
        .clk(clk), .rst_n(rst_n), .start(sc_start),
        .in_x(sc_in[0]), .in_y(sc_in[1]), .in_z(sc_in[2]),
        .done(sc_done), .zero(sc_zero),
        .out_x(sc_out[0]), .out_y(sc_out[1]), .out_z(sc_out[2])
    );

    function automatic logic [AW-1:0] vaddr(input logic [IdxW-1:0] v);
        logic [IdxW+AW-1:0] w;
        w = (IdxW+AW)'(v);
        return AW'(w % VertexCount);
    endfunction

    // corner address for the current step
    logic [AW-1:0] corner_addr;
    always_comb
    begin
        unique case (corner_reg)
            2'd0:    corner_addr = vaddr(item_reg.corner_a);
            2'd1:    corner_addr = vaddr(item_reg.corner_b);
            default: corner_addr = vaddr(item_reg.corner_c);
        endcase
    end

    // accumulator add with saturation
    logic [NW-1:0] acc_sum;
    always_comb
    begin
        logic signed [AccumWidth:0] s;
        logic signed [AccumWidth:0] hi;
        logic signed [AccumWidth:0] lo;
        hi = (AccumWidth+1)'((1 << (AccumWidth - 1)) - 1);
        lo = -hi - 1;
        for (int i = 0; i < 3; i++)
        begin
            s = (AccumWidth+1)'(signed'(acc_rdata[i*AccumWidth +: AccumWidth]))
                + (AccumWidth+1)'(n_reg[i]);
            if (s > hi)
            begin
                s = hi;
            end
            if (s < lo)
            begin
                s = lo;
            end
            acc_sum[i*AccumWidth +: AccumWidth] = s[AccumWidth-1:0];
        end
    end

    // ram port control
    always_comb
    begin
        pos_we    = 1'b0;
        pos_addr  = corner_addr;
        pos_wdata = {in_ch.payload.pos_z[CoordWidth-1:0], in_ch.payload.pos_y[CoordWidth-1:0],
                     in_ch.payload.pos_x[CoordWidth-1:0]};
        acc_we    = 1'b0;
        acc_addr  = corner_addr;
        acc_wdata = acc_sum;
        sc_start  = 1'b0;
        for (int i = 0; i < 3; i++)
        begin
            sc_in[i] = SIW'(cr_reg[i]);
        end
        if (state_reg == T_IDLE)
        begin
            pos_addr = vaddr(in_ch.payload.vertex_index);
            acc_addr = vaddr(in_ch.payload.vertex_index);
            if (in_ch.valid && in_ch.ready && in_ch.payload.action == ACT_LOAD)
            begin
                pos_we    = 1'b1;
                acc_we    = 1'b1;
                acc_wdata = '0;
            end
        end
        else if (state_reg == T_ACWR)
        begin
            acc_we = 1'b1;
        end
        else if (state_reg == T_RNRD)
        begin
            acc_addr = vaddr(item_reg.vertex_index);
        end
        if (state_reg == T_MUL && mul_reg == 2'd3)
        begin
            sc_start = 1'b1;
        end
        if (state_reg == T_RNGO)
        begin
            sc_start = 1'b1;
            for (int i = 0; i < 3; i++)
            begin
                sc_in[i] = SIW'(signed'(acc_rdata[i*AccumWidth +: AccumWidth]));
            end
        end
    end

    assign in_ch.ready = (state_reg == T_IDLE);

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= T_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                T_IDLE:
                begin
                    if (in_ch.valid && in_ch.ready)
                    begin
                        item_reg   <= in_ch.payload;
                        corner_reg <= 2'd0;
                        if (in_ch.payload.action == ACT_TRI)
                        begin
                            state_reg <= T_RDA;
                        end
                        else if (in_ch.payload.action == ACT_READ)
                        begin
                            state_reg <= T_RNRD;
                        end
                    end
                end
                T_RDA:
                begin
                    corner_reg <= 2'd1;
                    state_reg  <= T_RDB;
                end
                T_RDB:
                begin
                    for (int i = 0; i < 3; i++)
                    begin
                        pa_reg[i] <= pos_rdata[i*CoordWidth +: CoordWidth];
                    end
                    corner_reg <= 2'd2;
                    state_reg  <= T_RDC;
                end
                T_RDC:
                begin
                    for (int i = 0; i < 3; i++)
                    begin
                        pb_reg[i] <= pos_rdata[i*CoordWidth +: CoordWidth];
                    end
                    state_reg <= T_EDGE;
                end
                T_EDGE:
                begin
                    for (int i = 0; i < 3; i++)
                    begin
                        e1_reg[i] <= EW'(pb_reg[i]) - EW'(pa_reg[i]);
                        e2_reg[i] <= EW'(signed'(pos_rdata[i*CoordWidth +: CoordWidth]))
                                     - EW'(pa_reg[i]);
                    end
                    mul_reg   <= 2'd0;
                    state_reg <= T_MUL;
                end
                T_MUL:
                begin
                    // one cross component per cycle
                    unique case (mul_reg)
                        2'd0: cr_reg[0] <= CW'(e1_reg[1] * e2_reg[2]) - CW'(e1_reg[2] * e2_reg[1]);
                        2'd1: cr_reg[1] <= CW'(e1_reg[2] * e2_reg[0]) - CW'(e1_reg[0] * e2_reg[2]);
                        2'd2: cr_reg[2] <= CW'(e1_reg[0] * e2_reg[1]) - CW'(e1_reg[1] * e2_reg[0]);
                        default: state_reg <= T_SCALE;
                    endcase
                    mul_reg <= mul_reg + 2'd1;
                end
                T_SCALE:
                begin
                    if (sc_done)
                    begin
                        for (int i = 0; i < 3; i++)
                        begin
                            n_reg[i] <= sc_out[i];
                        end
                        corner_reg <= 2'd0;
                        state_reg  <= T_ACRD;
                    end
                end
                T_ACRD:
                begin
                    state_reg <= T_ACWR;
                end
                T_ACWR:
                begin
                    if (corner_reg == 2'd2)
                    begin
                        state_reg <= T_IDLE;
                    end
                    else
                    begin
                        corner_reg <= corner_reg + 2'd1;
                        state_reg  <= T_ACRD;
                    end
                end
                T_RNRD:
                begin
                    // wait here until the output register is free
                    if (!out_valid_reg)
                    begin
                        state_reg <= T_RNGO;
                    end
                end
                T_RNGO:
                begin
                    state_reg <= T_RNW;
                end
                T_RNW:
                begin
                    if (sc_done)
                    begin
                        out_reg.normal_x   <= sc_out[0];
                        out_reg.normal_y   <= sc_out[1];
                        out_reg.normal_z   <= sc_out[2];
                        out_reg.degenerate <= sc_zero;
                        out_valid_reg      <= 1'b1;
                        state_reg          <= T_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= T_IDLE;
                end
            endcase
        end
    end

    assign out_ch.valid   = out_valid_reg;
    assign out_ch.payload = out_reg;
endmodule
`default_nettype wire

// File: design/vna_checker.sv
// vna_checker: port-level checks on the vertex normal averager, bound to the top level
// depends on: vna_pkg, vertex_normal_averager
`default_nettype none
module vna_checker
    import vna_pkg::*;
(
    input wire logic     clk,
    input wire logic     rst_n,
    input wire logic     in_valid,
    input wire logic     in_ready,
    input wire vna_in_t  in_payload,
    input wire logic     out_valid,
    input wire logic     out_ready,
    input wire vna_out_t out_payload
);
    // result held while stalled
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_payload))
        else $error("result changed while stalled");

    // result fields known while offered
    a_out_known: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !$isunknown(out_payload))
        else $error("unknown bits in offered result");

    // a load never yields a result next cycle
    a_load_silent: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && in_payload.action == ACT_LOAD && !out_valid |=> !out_valid)
        else $error("load produced a result");

    // degenerate result carries zero normal
    a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_payload.degenerate |->
        out_payload.normal_x == '0 && out_payload.normal_y == '0 && out_payload.normal_z == '0)
        else $error("degenerate result with nonzero normal");
endmodule

bind vertex_normal_averager vna_checker u_vna_checker (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_payload(in_ch.payload),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_payload(out_ch.payload)
);
`default_nettype wire
